>>> hw/rtl/edtq_pkg.sv
`timescale 1ns / 1ps

package edtq_pkg;

    localparam int REMAIN_W    = 16;
    localparam int TAG_W       = 16;
    localparam int ID_W        = 32;
    localparam int PEND_W      = 5;
    localparam int MAX_RESULTS = 16;
    localparam int NFIRE_W     = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_CANCEL   = 2'd2,
        KIND_SHUTDOWN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FIRED   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_STOPPED = 2'd3
    } status_t;

    typedef struct packed {
        logic [REMAIN_W-1:0] remaining;
        logic [TAG_W-1:0]    tag;
        logic [ID_W-1:0]     id;
    } slot_t;

    typedef struct packed {
        status_t             status;
        logic [TAG_W-1:0]    fired_tag;
        logic [ID_W-1:0]     timer_id;
        logic [PEND_W-1:0]   pending_total;
        logic                last;
    } result_t;

endpackage

>>> hw/rtl/edtq_slot_ram.sv
`timescale 1ns / 1ps

module edtq_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  edtq_pkg::slot_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output edtq_pkg::slot_t rdata
);
    import edtq_pkg::*;

    slot_t mem [DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/edtq_seq.sv
`timescale 1ns / 1ps

module edtq_seq #(
    parameter int TIMER_SLOTS = 16,
    parameter int AW          = 4,
    parameter int CW          = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  edtq_pkg::kind_t               in_kind,
    input  logic [edtq_pkg::REMAIN_W-1:0] in_delay,
    input  logic [edtq_pkg::TAG_W-1:0]    in_tag,
    output logic                          res_valid,
    input  logic                          res_ready,
    output edtq_pkg::result_t             res,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output edtq_pkg::slot_t               mem_wdata,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_raddr,
    input  edtq_pkg::slot_t               mem_rdata
);
    import edtq_pkg::*;

    localparam int PW = (CW > PEND_W) ? CW : PEND_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_PACK_RD,
        S_PACK_EV,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [ID_W-1:0]        idc_reg, idc_next;
    logic                   stopped_reg, stopped_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic [CW-1:0]          pack_reg, pack_next;
    logic [NFIRE_W-1:0]     n_reg, n_next;
    logic                   pass_reg, pass_next;
    logic [TIMER_SLOTS-1:0] fired_reg, fired_next;
    logic                   hold_valid_reg, hold_valid_next;
    result_t                hold_reg, hold_next;

    logic [AW-1:0]          idx;
    logic                   due;
    logic [CW-1:0]          count_inc;
    logic [PW-1:0]          pend_inc_w, pend_cnt_w, pend_fire_w, pend_pack_w;

    assign idx         = scan_reg[AW-1:0];
    assign due         = !fired_reg[idx] && (mem_rdata.remaining == REMAIN_W'(pass_reg));
    assign count_inc   = count_reg + CW'(1);
    assign pend_inc_w  = PW'(count_inc);
    assign pend_cnt_w  = PW'(count_reg);
    assign pend_fire_w = PW'(count_reg) - PW'(n_reg) - PW'(1);
    assign pend_pack_w = PW'(pack_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idc_next        = idc_reg;
        stopped_next    = stopped_reg;
        scan_next       = scan_reg;
        pack_next       = pack_reg;
        n_next          = n_reg;
        pass_next       = pass_reg;
        fired_next      = fired_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        in_ready        = (state_reg == S_IDLE);
        res_valid       = 1'b0;
        res             = hold_reg;
        mem_we          = 1'b0;
        mem_waddr       = pack_reg[AW-1:0];
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    hold_next.fired_tag     = '0;
                    hold_next.timer_id      = '0;
                    hold_next.pending_total = '0;
                    hold_next.last          = 1'b1;
                    hold_next.status        = STAT_DONE;
                    unique case (in_kind)
                        KIND_SCHEDULE:
                        begin
                            idc_next           = idc_reg + ID_W'(1);
                            hold_next.timer_id = idc_reg;
                            hold_valid_next    = 1'b1;
                            state_next         = S_FINISH;
                            if (stopped_reg)
                            begin
                                hold_next.status        = STAT_STOPPED;
                                hold_next.pending_total = pend_cnt_w[PEND_W-1:0];
                            end
                            else if (count_reg == CW'(TIMER_SLOTS))
                            begin
                                hold_next.status        = STAT_FULL;
                                hold_next.pending_total = pend_cnt_w[PEND_W-1:0];
                            end
                            else
                            begin
                                mem_we                  = 1'b1;
                                mem_waddr               = count_reg[AW-1:0];
                                mem_wdata.remaining     = in_delay;
                                mem_wdata.tag           = in_tag;
                                mem_wdata.id            = idc_reg;
                                count_next              = count_inc;
                                hold_next.pending_total = pend_inc_w[PEND_W-1:0];
                            end
                        end
                        KIND_TICK:
                        begin
                            hold_valid_next = 1'b0;
                            scan_next       = '0;
                            pack_next       = '0;
                            n_next          = '0;
                            pass_next       = 1'b0;
                            fired_next      = '0;
                            state_next      = S_SCAN_RD;
                        end
                        KIND_CANCEL:
                        begin
                            count_next      = '0;
                            hold_valid_next = 1'b1;
                            state_next      = S_FINISH;
                        end
                        KIND_SHUTDOWN:
                        begin
                            count_next      = '0;
                            stopped_next    = 1'b1;
                            hold_valid_next = 1'b1;
                            state_next      = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (n_reg == NFIRE_W'(MAX_RESULTS))
                begin
                    scan_next  = '0;
                    state_next = S_PACK_RD;
                end
                else if (scan_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCAN_EV;
                end
                else if (!pass_reg)
                begin
                    pass_next = 1'b1;
                    scan_next = '0;
                end
                else
                begin
                    scan_next  = '0;
                    state_next = S_PACK_RD;
                end
            end
            S_SCAN_EV:
            begin
                if (!due)
                begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
                else if (!hold_valid_reg || res_ready)
                begin
                    res_valid               = hold_valid_reg;
                    hold_valid_next         = 1'b1;
                    hold_next.status        = STAT_FIRED;
                    hold_next.fired_tag     = mem_rdata.tag;
                    hold_next.timer_id      = mem_rdata.id;
                    hold_next.pending_total = pend_fire_w[PEND_W-1:0];
                    hold_next.last          = 1'b0;
                    fired_next[idx]         = 1'b1;
                    n_next                  = n_reg + NFIRE_W'(1);
                    scan_next               = scan_reg + CW'(1);
                    state_next              = S_SCAN_RD;
                end
            end
            S_PACK_RD:
            begin
                if (scan_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = S_PACK_EV;
                end
                else
                begin
                    count_next     = pack_reg;
                    hold_next.last = 1'b1;
                    if (!hold_valid_reg)
                    begin
                        hold_valid_next         = 1'b1;
                        hold_next.status        = STAT_DONE;
                        hold_next.fired_tag     = '0;
                        hold_next.timer_id      = '0;
                        hold_next.pending_total = pend_pack_w[PEND_W-1:0];
                    end
                    state_next = S_FINISH;
                end
            end
            S_PACK_EV:
            begin
                if (!fired_reg[idx])
                begin
                    mem_we    = 1'b1;
                    mem_wdata.remaining = (mem_rdata.remaining != '0)
                                          ? mem_rdata.remaining - REMAIN_W'(1) : '0;
                    pack_next = pack_reg + CW'(1);
                end
                scan_next  = scan_reg + CW'(1);
                state_next = S_PACK_RD;
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idc_reg        <= '0;
            stopped_reg    <= 1'b0;
            scan_reg       <= '0;
            pack_reg       <= '0;
            n_reg          <= '0;
            pass_reg       <= 1'b0;
            fired_reg      <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idc_reg        <= idc_next;
            stopped_reg    <= stopped_next;
            scan_reg       <= scan_next;
            pack_reg       <= pack_next;
            n_reg          <= n_next;
            pass_reg       <= pass_next;
            fired_reg      <= fired_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

`ifndef SYNTH
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held result left over in idle");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NFIRE_W'(MAX_RESULTS))
        else $error("too many firings on one tick");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TIMER_SLOTS))
        else $error("slot count beyond table size");

    a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (count_reg == '0))
        else $error("timers pending after shutdown");

    a_pack_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PACK_EV) |-> (pack_reg <= scan_reg))
        else $error("compaction write overtook read");
`endif

endmodule

>>> hw/rtl/earliest_deadline_timer_queue.sv
`timescale 1ns / 1ps

// one-shot timer table held in a single-port-read, single-port-write slot memory. schedule,
// cancel all and shutdown each hand one result to the output port. a tick walks the pending slots
// three times through the memory (due now, due next, then compaction with decrement), with a
// read state and an evaluate state per slot per walk, and it can stall while the result port is
// busy; ids come from a 32-bit counter that advances on every schedule request
module earliest_deadline_timer_queue #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // delay_ticks, callback_tag
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // fired_tag, timer_id, pending_total, zero pad
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);
    import edtq_pkg::*;

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    slot_t         mem_rdata;

    logic          out_valid_reg;
    result_t       out_reg;

    edtq_seq #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (kind_t'(s_axis_tuser)),
        .in_delay  (s_axis_tdata[15:0]),
        .in_tag    (s_axis_tdata[31:16]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    edtq_slot_ram #(
        .DEPTH (TIMER_SLOTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {3'b000, out_reg.pending_total, out_reg.timer_id, out_reg.fired_tag};

endmodule
